FILE: rtl/wps_pkg.sv
`default_nettype none

package wps_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] byte_in;
   } wps_req_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] sample;
      logic [3:0]         status;
      logic               last_of_run;
   } wps_rsp_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [3:0] ST_OK             = 4'd0;
   localparam logic [3:0] ST_NOT_RIFF       = 4'd1;
   localparam logic [3:0] ST_SHORT_RIFF     = 4'd2;
   localparam logic [3:0] ST_NOT_WAVE       = 4'd3;
   localparam logic [3:0] ST_SHORT_FMT      = 4'd4;
   localparam logic [3:0] ST_NON_PCM        = 4'd5;
   localparam logic [3:0] ST_DATA_BEFORE    = 4'd6;
   localparam logic [3:0] ST_SHORT_DATA     = 4'd7;
   localparam logic [3:0] ST_MISSING_CHUNKS = 4'd8;
   localparam logic [3:0] ST_WRONG_FORMAT   = 4'd9;

   localparam logic       CSR_EXPECTED_RATE     = 1'b0;
   localparam logic       CSR_EXPECTED_CHANNELS = 1'b1;
   localparam logic [31:0] RESET_RATE     = 32'd16000;
   localparam logic [15:0] RESET_CHANNELS = 16'd1;

   // tags as they sit in the little-endian shifter
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FORMAT_PCM  = 16'd1;
   localparam logic [15:0] PCM_BITS    = 16'd16;
   localparam logic [31:0] FMT_BODY_LEN = 32'd16;

endpackage

`default_nettype wire

FILE: rtl/wps_parser.sv
`default_nettype none

module wps_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire wps_pkg::wps_req_type item,
   input  wire logic [31:0]          expected_rate,
   input  wire logic [15:0]          expected_channels,
   output logic [1:0]                res_cnt,
   output wps_pkg::wps_rsp_type      res0,
   output wps_pkg::wps_rsp_type      res1
);
   import wps_pkg::*;

   localparam logic [3:0] PH_RIFF  = 4'd0;
   localparam logic [3:0] PH_RSIZE = 4'd1;
   localparam logic [3:0] PH_WAVE  = 4'd2;
   localparam logic [3:0] PH_CID   = 4'd3;
   localparam logic [3:0] PH_CSIZE = 4'd4;
   localparam logic [3:0] PH_FMT   = 4'd5;
   localparam logic [3:0] PH_FSKIP = 4'd6;
   localparam logic [3:0] PH_OSKIP = 4'd7;
   localparam logic [3:0] PH_DATA  = 4'd8;
   localparam logic [3:0] PH_DONE  = 4'd9;

   localparam logic [1:0] CK_OTHER = 2'd0;
   localparam logic [1:0] CK_FMT   = 2'd1;
   localparam logic [1:0] CK_DATA  = 2'd2;

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] rem_ff, rem_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [15:0] format_code_ff, format_code_in;
   logic [15:0] channel_ff, channel_in;
   logic [31:0] rate_ff, rate_in;
   logic        good_ff, good_in;
   logic [8:0]  hold_ff, hold_in;
   logic [1:0]  ckind_ff, ckind_in;

   logic [31:0] shift_nx;
   logic [31:0] rem_dec;
   logic [31:0] fmt_rem;
   logic        field_done;

   function automatic wps_rsp_type make_status(input logic [3:0] st);
      wps_rsp_type r;
      r.kind        = KIND_STATUS;
      r.sample      = '0;
      r.status      = st;
      r.last_of_run = 1'b1;
      return r;
   endfunction

   assign shift_nx   = {item.byte_in, shift_ff[31:8]};
   assign rem_dec    = rem_ff - 32'd1;
   assign fmt_rem    = (rem_ff > FMT_BODY_LEN) ? rem_ff - FMT_BODY_LEN : 32'd0;
   assign field_done = (fbc_ff >= 4'd3);

   always_comb begin
      phase_in       = phase_ff;
      fbc_in         = fbc_ff;
      shift_in       = shift_ff;
      rem_in         = rem_ff;
      fmt_seen_in    = fmt_seen_ff;
      format_code_in = format_code_ff;
      channel_in     = channel_ff;
      rate_in        = rate_ff;
      good_in        = good_ff;
      hold_in        = hold_ff;
      ckind_in       = ckind_ff;
      res_cnt        = 2'd0;
      res0           = '0;
      res1           = '0;

      if (item_valid) begin
         if (item.cmd == CMD_END) begin
            res_cnt = 2'd1;
            case (phase_ff)
               PH_RIFF:  res0 = make_status(ST_NOT_RIFF);
               PH_RSIZE: res0 = make_status(ST_SHORT_RIFF);
               PH_WAVE:  res0 = make_status(ST_NOT_WAVE);
               PH_FMT:   res0 = make_status(ST_SHORT_FMT);
               PH_DATA:  res0 = make_status(ST_SHORT_DATA);
               PH_DONE:  res_cnt = 2'd0;
               default:  res0 = make_status(ST_MISSING_CHUNKS);
            endcase
            phase_in       = PH_RIFF;
            fbc_in         = '0;
            shift_in       = '0;
            rem_in         = '0;
            fmt_seen_in    = 1'b0;
            format_code_in = '0;
            channel_in     = '0;
            rate_in        = '0;
            good_in        = 1'b0;
            hold_in        = '0;
            ckind_in       = CK_OTHER;
         end else begin
            case (phase_ff)
               PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
                  shift_in = shift_nx;
                  fbc_in   = field_done ? 4'd0 : fbc_ff + 4'd1;
                  if (field_done) begin
                     case (phase_ff)
                        PH_RIFF: begin
                           if (shift_nx != TAG_RIFF) begin
                              res_cnt  = 2'd1;
                              res0     = make_status(ST_NOT_RIFF);
                              phase_in = PH_DONE;
                           end else begin
                              phase_in = PH_RSIZE;
                           end
                        end
                        PH_RSIZE: phase_in = PH_WAVE;
                        PH_WAVE: begin
                           if (shift_nx != TAG_WAVE) begin
                              res_cnt  = 2'd1;
                              res0     = make_status(ST_NOT_WAVE);
                              phase_in = PH_DONE;
                           end else begin
                              phase_in = PH_CID;
                           end
                        end
                        PH_CID: begin
                           if (shift_nx == TAG_FMT) begin
                              ckind_in = CK_FMT;
                           end else if (shift_nx == TAG_DATA) begin
                              ckind_in = CK_DATA;
                           end else begin
                              ckind_in = CK_OTHER;
                           end
                           phase_in = PH_CSIZE;
                        end
                        default: begin
                           // chunk size complete
                           rem_in = shift_nx;
                           if (ckind_ff == CK_FMT) begin
                              phase_in = PH_FMT;
                           end else if (ckind_ff == CK_DATA) begin
                              if (!fmt_seen_ff) begin
                                 res_cnt  = 2'd1;
                                 res0     = make_status(ST_DATA_BEFORE);
                                 phase_in = PH_DONE;
                              end else begin
                                 hold_in = '0;
                                 if (shift_nx == 32'd0) begin
                                    res_cnt  = 2'd1;
                                    res0     = make_status(good_ff ? ST_OK : ST_WRONG_FORMAT);
                                    phase_in = PH_DONE;
                                 end else begin
                                    phase_in = PH_DATA;
                                 end
                              end
                           end else begin
                              phase_in = (shift_nx == 32'd0) ? PH_CID : PH_OSKIP;
                           end
                        end
                     endcase
                  end
               end
               PH_FMT: begin
                  shift_in = shift_nx;
                  fbc_in   = fbc_ff + 4'd1;
                  case (fbc_ff)
                     4'd1: format_code_in = shift_nx[31:16];
                     4'd3: channel_in     = shift_nx[31:16];
                     4'd7: rate_in        = shift_nx;
                     4'd15: begin
                        fbc_in = 4'd0;
                        if (format_code_ff != FORMAT_PCM) begin
                           res_cnt  = 2'd1;
                           res0     = make_status(ST_NON_PCM);
                           phase_in = PH_DONE;
                        end else begin
                           fmt_seen_in = 1'b1;
                           good_in     = (channel_ff == expected_channels) &&
                                         (rate_ff == expected_rate) &&
                                         (shift_nx[31:16] == PCM_BITS);
                           rem_in      = fmt_rem;
                           phase_in    = (fmt_rem == 32'd0) ? PH_CID : PH_FSKIP;
                        end
                     end
                     default: ;
                  endcase
               end
               PH_FSKIP, PH_OSKIP: begin
                  rem_in = rem_dec;
                  if (rem_dec == 32'd0) begin
                     phase_in = PH_CID;
                  end
               end
               PH_DATA: begin
                  if (hold_ff[8]) begin
                     hold_in = '0;
                     if (good_ff) begin
                        res_cnt          = 2'd1;
                        res0.kind        = KIND_SAMPLE;
                        res0.sample      = {item.byte_in, hold_ff[7:0]};
                        res0.status      = ST_OK;
                        res0.last_of_run = 1'b1;
                     end
                  end else begin
                     hold_in = {1'b1, item.byte_in};
                  end
                  rem_in = rem_dec;
                  if (rem_dec == 32'd0) begin
                     phase_in = PH_DONE;
                     if (hold_ff[8] && good_ff) begin
                        // sample goes first, status follows it
                        res_cnt          = 2'd2;
                        res0.last_of_run = 1'b0;
                        res1             = make_status(ST_OK);
                     end else begin
                        res_cnt = 2'd1;
                        res0    = make_status(good_ff ? ST_OK : ST_WRONG_FORMAT);
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_RIFF;
         fbc_ff         <= '0;
         shift_ff       <= '0;
         rem_ff         <= '0;
         fmt_seen_ff    <= 1'b0;
         format_code_ff <= '0;
         channel_ff     <= '0;
         rate_ff        <= '0;
         good_ff        <= 1'b0;
         hold_ff        <= '0;
         ckind_ff       <= CK_OTHER;
      end else begin
         phase_ff       <= phase_in;
         fbc_ff         <= fbc_in;
         shift_ff       <= shift_in;
         rem_ff         <= rem_in;
         fmt_seen_ff    <= fmt_seen_in;
         format_code_ff <= format_code_in;
         channel_ff     <= channel_in;
         rate_ff        <= rate_in;
         good_ff        <= good_in;
         hold_ff        <= hold_in;
         ckind_ff       <= ckind_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/wps_rsp_fifo.sv
`default_nettype none

module wps_rsp_fifo #(
   parameter int Depth = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [1:0]                   push_cnt,
   input  wire wps_pkg::wps_rsp_type         push0,
   input  wire wps_pkg::wps_rsp_type         push1,
   input  wire logic                         pop,
   output logic                              out_valid,
   output wps_pkg::wps_rsp_type              out_data,
   output logic [$clog2(Depth):0]            level
);
   import wps_pkg::*;

   localparam int AW = $clog2(Depth);

   wps_rsp_type     mem_ff [Depth];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     level_ff, level_in;
   logic            do_pop;
   logic [AW-1:0]   wr_next;

   assign do_pop    = pop && (level_ff != '0);
   assign wr_next   = wr_ptr_ff + AW'(1);
   assign wr_ptr_in = wr_ptr_ff + AW'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + AW'(do_pop);
   assign level_in  = level_ff + (AW+1)'(push_cnt) - (AW+1)'(do_pop);

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/wav_pcm_stream_parser_core.sv
// RIFF/WAVE PCM stream parser.
// req channel: one transfer per file byte (cmd = byte) or end-of-stream mark
// (cmd = end). rsp channel: PCM samples (kind = sample) and exactly one final
// status per file (kind = status); last_of_run flags the final result of an
// input item. csr port: index 0 expected sample rate, index 1 expected
// channel count, to be written by the user only while the block is idle; the
// block itself does not enforce this. A byte is registered at its transfer
// and parsed in the next cycle; its results enter the result queue at the
// following edge, and rsp_valid comes from the queue's registered level.
// Throughput: one byte per cycle while req_ready is high. An item that
// yields two results (last sample plus status) pushes both into the queue
// at once; the queue absorbs these.
// req_ready drops when the result queue could not take two more results for
// the item in the input register and two for the next one, so a stalled
// receiver back-pressures the byte stream after the queue fills; nothing is lost.
// Reset clears the parse state and queue and restores rate 16000, one
// channel. After end of stream the parser returns to its reset state with the
// registers kept.
`default_nettype none

module wav_pcm_stream_parser_core #(
   parameter int FifoDepth = 8  // power of two, at least 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire wps_pkg::wps_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output wps_pkg::wps_rsp_type      rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_index,
   input  wire logic [31:0]          csr_wr_data
);
   import wps_pkg::*;

   localparam int LW = $clog2(FifoDepth) + 1;

   logic        in_valid_ff, in_valid_in;
   wps_req_type in_item_ff;
   logic [31:0] rate_ff;
   logic [15:0] channels_ff;

   logic [1:0]    res_cnt;
   wps_rsp_type   res0, res1;
   logic [LW-1:0] level;
   logic [LW:0]   demand;

   assign demand      = {1'b0, level} + (LW+1)'(in_valid_ff ? 4 : 2);
   assign req_ready   = (demand <= (LW+1)'(FifoDepth));
   assign in_valid_in = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rate_ff     <= RESET_RATE;
         channels_ff <= RESET_CHANNELS;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en && csr_index == CSR_EXPECTED_RATE) begin
            rate_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == CSR_EXPECTED_CHANNELS) begin
            channels_ff <= csr_wr_data[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_item_ff <= req_data;
      end
   end

   wps_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (in_valid_ff),
      .item              (in_item_ff),
      .expected_rate     (rate_ff),
      .expected_channels (channels_ff),
      .res_cnt           (res_cnt),
      .res0              (res0),
      .res1              (res1)
   );

   wps_rsp_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (res_cnt),
      .push0     (res0),
      .push1     (res1),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .level     (level)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      level <= LW'(FifoDepth))
      else $error("result queue overflow");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |-> rsp_data.last_of_run)
      else $error("status result not flagged last");

   a_sample_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_SAMPLE |-> rsp_data.status == ST_OK)
      else $error("sample result carries a status");

   a_two_only_last: assert property (@(posedge clock) disable iff (reset)
      res_cnt == 2'd2 |-> !res0.last_of_run && res1.last_of_run)
      else $error("two-result item flagged wrong");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> res_cnt == 2'd0)
      else $error("result without an item");

endmodule

`default_nettype wire
